[hdl/pat_leaky_bucket_detector_defines.svh]
// ----------------------------------------------------------------------------
// pat leaky bucket detector assertion macros
// concurrent checks clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PAT_LEAKY_BUCKET_DETECTOR_DEFINES_SVH
`define PAT_LEAKY_BUCKET_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define PLD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pld implication check failed");
// condition never holds
`define PLD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("pld forbidden condition seen");
`else
`define PLD_ASSERT_IMP(label, ante, cons)
`define PLD_ASSERT_NEVER(label, cond)
`endif

`endif

[hdl/pld_pkg.sv]
// ----------------------------------------------------------------------------
// pld_pkg
// shared types and constants of the pat leaky bucket detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pld_pkg;

	// field widths
	localparam int TIME_W  = 32;
	localparam int MAG_W   = 16;
	localparam int LEVEL_W = 15;
	localparam int CODE_W  = 4;
	localparam int REG16_W = 16;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	// full happiness, 100.0 in q7.8
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 15'd25600;

	// floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every x below 2^31
	localparam logic [31:0] RECIP_1000  = 32'd2199023256;
	localparam int          RECIP_SHIFT = 41;
	localparam int          SCALED_W    = LEVEL_W + 32;
	localparam int          PROD_W      = SCALED_W + REG16_W;
	localparam int          LOSS_W      = PROD_W - RECIP_SHIFT;

	// register indexes
	localparam logic [2:0] REG_COOL_TILT = 3'd0;
	localparam logic [2:0] REG_MAX_GAP   = 3'd1;
	localparam logic [2:0] REG_LEAK_RATE = 3'd2;
	localparam logic [2:0] REG_SPIKE_THR = 3'd3;
	localparam logic [2:0] REG_SPIKE_CD  = 3'd4;
	localparam logic [2:0] REG_GAIN      = 3'd5;
	localparam logic [2:0] REG_START     = 3'd6;
	localparam logic [2:0] REG_END       = 3'd7;

	// register reset values
	localparam logic [REG16_W-1:0] RST_COOL_TILT = 16'd0;
	localparam logic [REG16_W-1:0] RST_MAX_GAP   = 16'd1000;
	localparam logic [LEVEL_W-1:0] RST_LEAK_RATE = 15'd2560;
	localparam logic [REG16_W-1:0] RST_SPIKE_THR = 16'd512;
	localparam logic [REG16_W-1:0] RST_SPIKE_CD  = 16'd200;
	localparam logic [LEVEL_W-1:0] RST_GAIN      = 15'd5120;
	localparam logic [LEVEL_W-1:0] RST_START     = 15'd12800;
	localparam logic [LEVEL_W-1:0] RST_END       = 15'd2560;
	localparam logic [SCALED_W-1:0] RST_LEAK_SCALED =
		SCALED_W'(64'(RST_LEAK_RATE) * 64'(RECIP_1000));

	// event codes of a result
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_END   = 2'd2
	} pld_event_t;

	// configuration seen by the core
	typedef struct packed {
		logic [REG16_W-1:0]  cool_tilt;
		logic [REG16_W-1:0]  max_gap;
		logic [SCALED_W-1:0] leak_scaled;
		logic [REG16_W-1:0]  spike_thr;
		logic [REG16_W-1:0]  spike_cd;
		logic [LEVEL_W-1:0]  gain;
		logic [LEVEL_W-1:0]  start_level;
		logic [LEVEL_W-1:0]  end_level;
	} pld_cfg_t;

endpackage

`default_nettype wire

[hdl/pld_in_if.sv]
// ----------------------------------------------------------------------------
// pld_in_if
// sample request channel: valid, ready and one accelerometer sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pld_in_if import pld_pkg::*;;
	logic               valid;
	logic               ready;
	logic [TIME_W-1:0]  now_ms;
	logic [MAG_W-1:0]   magnitude;
	logic [TIME_W-1:0]  tilt_neutral_ms;
	logic [CODE_W-1:0]  eye_now;
	logic [CODE_W-1:0]  mouth_now;

	modport source (
		output valid, now_ms, magnitude, tilt_neutral_ms, eye_now, mouth_now,
		input  ready
	);
	modport sink (
		input  valid, now_ms, magnitude, tilt_neutral_ms, eye_now, mouth_now,
		output ready
	);
endinterface

`default_nettype wire

[hdl/pld_out_if.sv]
// ----------------------------------------------------------------------------
// pld_out_if
// result request channel: valid, ready and one detector result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pld_out_if import pld_pkg::*;;
	logic               valid;
	logic               ready;
	pld_event_t         event_res;
	logic [CODE_W-1:0]  restore_eye;
	logic [CODE_W-1:0]  restore_mouth;
	logic [LEVEL_W-1:0] happiness;
	logic               responding;
	logic               pat_counted;

	modport source (
		output valid, event_res, restore_eye, restore_mouth, happiness,
		       responding, pat_counted,
		input  ready
	);
	modport sink (
		input  valid, event_res, restore_eye, restore_mouth, happiness,
		       responding, pat_counted,
		output ready
	);
endinterface

`default_nettype wire

[hdl/pld_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pld_cfg_regs
// apb register file; also keeps leak rate pre-scaled by the 1/1000 reciprocal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_cfg_regs import pld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output pld_cfg_t           cfg
);

	logic [REG16_W-1:0]  cool_tilt_q;
	logic [REG16_W-1:0]  max_gap_q;
	logic [LEVEL_W-1:0]  leak_rate_q;
	logic [SCALED_W-1:0] leak_scaled_q;
	logic [REG16_W-1:0]  spike_thr_q;
	logic [REG16_W-1:0]  spike_cd_q;
	logic [LEVEL_W-1:0]  gain_q;
	logic [LEVEL_W-1:0]  start_q;
	logic [LEVEL_W-1:0]  end_q;
	logic                wr_en;
	logic [2:0]          reg_idx;
	logic [SCALED_W-1:0] scaled_wr;

	assign pready    = 1'b1;
	assign wr_en     = psel & penable & pwrite & pready;
	assign reg_idx   = paddr[PADDR_W-1:2];
	assign scaled_wr = pwdata[LEVEL_W-1:0] * RECIP_1000;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_tilt_q   <= RST_COOL_TILT;
			max_gap_q     <= RST_MAX_GAP;
			leak_rate_q   <= RST_LEAK_RATE;
			leak_scaled_q <= RST_LEAK_SCALED;
			spike_thr_q   <= RST_SPIKE_THR;
			spike_cd_q    <= RST_SPIKE_CD;
			gain_q        <= RST_GAIN;
			start_q       <= RST_START;
			end_q         <= RST_END;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_COOL_TILT: cool_tilt_q <= pwdata[REG16_W-1:0];
				REG_MAX_GAP:   max_gap_q   <= pwdata[REG16_W-1:0];
				REG_LEAK_RATE: begin
					leak_rate_q   <= pwdata[LEVEL_W-1:0];
					leak_scaled_q <= scaled_wr;
				end
				REG_SPIKE_THR: spike_thr_q <= pwdata[REG16_W-1:0];
				REG_SPIKE_CD:  spike_cd_q  <= pwdata[REG16_W-1:0];
				REG_GAIN:      gain_q      <= pwdata[LEVEL_W-1:0];
				REG_START:     start_q     <= pwdata[LEVEL_W-1:0];
				REG_END:       end_q       <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_COOL_TILT: prdata = DATA_W'(cool_tilt_q);
			REG_MAX_GAP:   prdata = DATA_W'(max_gap_q);
			REG_LEAK_RATE: prdata = DATA_W'(leak_rate_q);
			REG_SPIKE_THR: prdata = DATA_W'(spike_thr_q);
			REG_SPIKE_CD:  prdata = DATA_W'(spike_cd_q);
			REG_GAIN:      prdata = DATA_W'(gain_q);
			REG_START:     prdata = DATA_W'(start_q);
			REG_END:       prdata = DATA_W'(end_q);
			default:       prdata = '0;
		endcase
	end

	// config bundle to the core
	always_comb begin
		cfg.cool_tilt   = cool_tilt_q;
		cfg.max_gap     = max_gap_q;
		cfg.leak_scaled = leak_scaled_q;
		cfg.spike_thr   = spike_thr_q;
		cfg.spike_cd    = spike_cd_q;
		cfg.gain        = gain_q;
		cfg.start_level = start_q;
		cfg.end_level   = end_q;
	end

endmodule

`default_nettype wire

[hdl/pld_core.sv]
// ----------------------------------------------------------------------------
// pld_core
// input register, single-pass leak / pat / hysteresis update, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pld_core import pld_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pld_cfg_t cfg,
	pld_in_if.sink   sample,
	pld_out_if.source result
);

	// input register
	logic               valid_s1;
	logic [TIME_W-1:0]  now_s1;
	logic [MAG_W-1:0]   mag_s1;
	logic [TIME_W-1:0]  neutral_s1;
	logic [CODE_W-1:0]  eye_s1;
	logic [CODE_W-1:0]  mouth_s1;

	// result register
	logic               valid_s2;
	pld_event_t         event_s2;
	logic [CODE_W-1:0]  r_eye_s2;
	logic [CODE_W-1:0]  r_mouth_s2;
	logic [LEVEL_W-1:0] level_s2;
	logic               active_s2;
	logic               pat_s2;

	// detector state
	logic [TIME_W-1:0]  last_update_q;
	logic [LEVEL_W-1:0] level_q;
	logic [MAG_W-1:0]   prev_mag_q;
	logic [TIME_W-1:0]  last_pat_q;
	logic               active_q;
	logic [CODE_W-1:0]  saved_eye_q;
	logic [CODE_W-1:0]  saved_mouth_q;

	// step logic
	logic               adv_s2;
	logic               step;
	logic               in_cool;
	logic [TIME_W-1:0]  since_tilt;
	logic [TIME_W-1:0]  base_ms;
	logic [TIME_W-1:0]  elapsed;
	logic               leak_en;
	logic [PROD_W-1:0]  prod;
	logic [LOSS_W-1:0]  loss;
	logic [LEVEL_W-1:0] leaked;
	logic [MAG_W-1:0]   delta;
	logic [TIME_W-1:0]  since_pat;
	logic               pat;
	logic [LEVEL_W:0]   sum;
	logic [LEVEL_W-1:0] lvl_pat;
	pld_event_t         ev;
	logic [LEVEL_W-1:0] lvl_next;
	logic               active_next;

	// handshake
	assign adv_s2       = !valid_s2 || result.ready;
	assign step         = valid_s1 && adv_s2;
	assign sample.ready = !valid_s1 || adv_s2;

	// tilt cooldown
	assign since_tilt = now_s1 - neutral_s1;
	assign in_cool    = (cfg.cool_tilt != '0) && (since_tilt < TIME_W'(cfg.cool_tilt));

	// leak: loss = floor(rate * elapsed / 1000) via pre-scaled rate
	assign base_ms = (last_update_q == '0) ? now_s1 : last_update_q;
	assign elapsed = now_s1 - base_ms;
	assign leak_en = (elapsed != '0) && (elapsed < TIME_W'(cfg.max_gap));
	assign prod    = cfg.leak_scaled * elapsed[REG16_W-1:0];
	assign loss    = prod[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		if (!leak_en)
			leaked = level_q;
		else if (loss >= LOSS_W'(level_q))
			leaked = '0;
		else
			leaked = level_q - loss[LEVEL_W-1:0];
	end

	// pat detection and gain with saturation
	assign delta     = (mag_s1 >= prev_mag_q) ? mag_s1 - prev_mag_q : prev_mag_q - mag_s1;
	assign since_pat = now_s1 - last_pat_q;
	assign pat       = (delta >= cfg.spike_thr) && (since_pat >= TIME_W'(cfg.spike_cd));
	assign sum       = {1'b0, leaked} + {1'b0, cfg.gain};

	always_comb begin
		if (!pat)
			lvl_pat = leaked;
		else if (sum > {1'b0, LEVEL_FULL})
			lvl_pat = LEVEL_FULL;
		else
			lvl_pat = sum[LEVEL_W-1:0];
	end

	// hysteresis
	always_comb begin
		ev          = EV_NONE;
		lvl_next    = lvl_pat;
		active_next = active_q;
		if (!active_q) begin
			if (lvl_pat >= cfg.start_level) begin
				ev          = EV_START;
				active_next = 1'b1;
			end
		end else if (lvl_pat < cfg.end_level) begin
			ev          = EV_END;
			active_next = 1'b0;
			lvl_next    = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			now_s1     <= sample.now_ms;
			mag_s1     <= sample.magnitude;
			neutral_s1 <= sample.tilt_neutral_ms;
			eye_s1     <= sample.eye_now;
			mouth_s1   <= sample.mouth_now;
		end
	end

	// state update, one request per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_update_q <= '0;
			level_q       <= '0;
			prev_mag_q    <= '0;
			last_pat_q    <= '0;
			active_q      <= 1'b0;
			saved_eye_q   <= '0;
			saved_mouth_q <= '0;
		end else if (step && !in_cool) begin
			last_update_q <= now_s1;
			level_q       <= lvl_next;
			prev_mag_q    <= mag_s1;
			active_q      <= active_next;
			if (pat) begin
				last_pat_q <= now_s1;
			end
			if (ev == EV_START) begin
				saved_eye_q   <= eye_s1;
				saved_mouth_q <= mouth_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (in_cool) begin
				event_s2   <= EV_NONE;
				r_eye_s2   <= '0;
				r_mouth_s2 <= '0;
				level_s2   <= level_q;
				active_s2  <= active_q;
				pat_s2     <= 1'b0;
			end else begin
				event_s2   <= ev;
				r_eye_s2   <= (ev == EV_END) ? saved_eye_q : '0;
				r_mouth_s2 <= (ev == EV_END) ? saved_mouth_q : '0;
				level_s2   <= lvl_next;
				active_s2  <= active_next;
				pat_s2     <= pat;
			end
		end
	end

	assign result.valid         = valid_s2;
	assign result.event_res     = event_s2;
	assign result.restore_eye   = r_eye_s2;
	assign result.restore_mouth = r_mouth_s2;
	assign result.happiness     = level_s2;
	assign result.responding    = active_s2;
	assign result.pat_counted   = pat_s2;

endmodule

`default_nettype wire

[hdl/pat_leaky_bucket_detector.sv]
// ----------------------------------------------------------------------------
// pat_leaky_bucket_detector
// petting detector on a leaky happiness bucket with start / end hysteresis
// ----------------------------------------------------------------------------
//  channel   role         payload
//  sample    request in   now_ms, magnitude, tilt_neutral_ms, eye_now, mouth_now
//  result    request out  event_res, restore_eye, restore_mouth, happiness,
//                         responding, pat_counted
//  apb       config       eight registers at byte address 4*index
//
//  one sample per cycle unless result stalls; passes input then result register
//  the level loop closes through one 47x16 multiply for the leak
//  reset clears state and restores register defaults, no clearing pass
//  a stalled result holds the result register; the input register keeps
//  accepting while the result register can drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pat_leaky_bucket_detector_defines.svh"

module pat_leaky_bucket_detector import pld_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pld_in_if.sink             sample,
	pld_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	pld_cfg_t cfg;

	// register file
	pld_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// detector datapath
	pld_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

	// checks
	`PLD_ASSERT_NEVER(a_level_bound, result.valid && (result.happiness > LEVEL_FULL))
	`PLD_ASSERT_IMP(a_end_clears, result.valid && (result.event_res == EV_END), !result.responding && (result.happiness == '0))
	`PLD_ASSERT_IMP(a_start_active, result.valid && (result.event_res == EV_START), result.responding)
	`PLD_ASSERT_IMP(a_restore_idle, result.valid && (result.event_res != EV_END), (result.restore_eye == '0) && (result.restore_mouth == '0))

endmodule

`default_nettype wire

[tb/sv/pat_leaky_bucket_detector_tb.sv]
// ----------------------------------------------------------------------------
// pat_leaky_bucket_detector_tb
// self-checking bench for the pat detector: samples go in through a queued
// driver, every result is checked field by field against a bit-exact
// predictor of the happiness bucket, across several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pat_leaky_bucket_detector_tb;
	import pld_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 100;

	// register setting kinds of the random phases
	localparam int CFG_TYPICAL = 0;
	localparam int CFG_ZERO    = 1;
	localparam int CFG_FULL    = 2;
	localparam int CFG_RESET   = 3;

	typedef struct {
		logic [TIME_W-1:0] now;
		logic [MAG_W-1:0]  mag;
		logic [TIME_W-1:0] tilt;
		logic [CODE_W-1:0] eye;
		logic [CODE_W-1:0] mouth;
	} sample_t;

	typedef struct {
		pld_event_t         ev;
		logic [CODE_W-1:0]  r_eye;
		logic [CODE_W-1:0]  r_mouth;
		logic [LEVEL_W-1:0] happy;
		logic               active;
		logic               pat;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	pld_in_if  sample_bus ();
	pld_out_if result_bus ();

	pat_leaky_bucket_detector i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	// pending samples and expected outcomes
	sample_t  sample_q[$];
	outcome_t happy_q[$];

	// predictor copy of the registers
	logic [REG16_W-1:0] c_cool, c_max_gap, c_thr, c_cd;
	logic [LEVEL_W-1:0] c_leak, c_gain, c_start, c_end;

	// predictor copy of the bucket state
	logic [TIME_W-1:0]  b_last_upd, b_last_pat;
	logic [LEVEL_W-1:0] b_level;
	logic [MAG_W-1:0]   b_prev_mag;
	logic               b_active;
	logic [CODE_W-1:0]  b_saved_eye, b_saved_mouth;

	int err_count    = 0;
	int queued_total = 0;
	int in_count     = 0;
	int res_count    = 0;
	int idle_cycles  = 0;
	int n_pat = 0, n_start = 0, n_end = 0, n_ignored = 0, n_settings = 0;
	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;
	bit calm      = 1'b0;
	bit cfg_junk  = 1'b0;
	int in_gap    = 0;
	int out_gap   = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	logic [TIME_W-1:0] gen_t;
	int                gen_mag;

	// one sample through the bucket, updates the predictor state
	function automatic outcome_t bucket_step(sample_t s);
		outcome_t          o;
		logic [TIME_W-1:0] elapsed;
		logic [63:0]       loss;
		logic [MAG_W-1:0]  delta;
		logic [31:0]       sum;
		o.ev      = EV_NONE;
		o.r_eye   = '0;
		o.r_mouth = '0;
		o.pat     = 1'b0;
		if (c_cool != 0 && (s.now - s.tilt) < c_cool) begin
			n_ignored++;
		end else begin
			if (b_last_upd == 0)
				b_last_upd = s.now;
			elapsed    = s.now - b_last_upd;
			b_last_upd = s.now;
			// leak only inside the gap window, floor and clamp at empty
			if (elapsed > 0 && elapsed < c_max_gap) begin
				loss    = (64'(c_leak) * 64'(elapsed)) / 64'd1000;
				b_level = (loss >= 64'(b_level)) ? '0 : b_level - LEVEL_W'(loss);
			end
			delta      = (s.mag >= b_prev_mag) ? s.mag - b_prev_mag : b_prev_mag - s.mag;
			b_prev_mag = s.mag;
			// counted pat
			if (delta >= c_thr && (s.now - b_last_pat) >= TIME_W'(c_cd)) begin
				b_last_pat = s.now;
				sum        = 32'(b_level) + 32'(c_gain);
				b_level    = (sum > 32'(LEVEL_FULL)) ? LEVEL_FULL : LEVEL_W'(sum);
				o.pat      = 1'b1;
				n_pat++;
			end
			// start / end hysteresis
			if (!b_active) begin
				if (b_level >= c_start) begin
					b_active      = 1'b1;
					b_saved_eye   = s.eye;
					b_saved_mouth = s.mouth;
					o.ev          = EV_START;
					n_start++;
				end
			end else if (b_level < c_end) begin
				b_active  = 1'b0;
				b_level   = '0;
				o.ev      = EV_END;
				o.r_eye   = b_saved_eye;
				o.r_mouth = b_saved_mouth;
				n_end++;
			end
		end
		o.happy  = b_level;
		o.active = b_active;
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d actual %0d", name, want, got);
			err_count++;
		end
	endfunction

	// mostly short gaps, a few long, none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic push_sample(input logic [31:0] now, input logic [15:0] mag,
			input logic [31:0] tilt, input logic [3:0] eye, input logic [3:0] mouth);
		sample_t s;
		s.now   = now;
		s.mag   = mag;
		s.tilt  = tilt;
		s.eye   = eye;
		s.mouth = mouth;
		sample_q.push_back(s);
		queued_total++;
	endtask

	// apb write: setup then access, register taken at the access edge
	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		logic [31:0] data;
		data = {16'h0000, val};
		if (cfg_junk) begin
			data[31:16] = 16'($urandom);
			if (idx inside {REG_LEAK_RATE, REG_GAIN, REG_START, REG_END})
				data[15] = 1'($urandom_range(0, 1));
		end
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_COOL_TILT: c_cool    = data[15:0];
			REG_MAX_GAP:   c_max_gap = data[15:0];
			REG_LEAK_RATE: c_leak    = data[14:0];
			REG_SPIKE_THR: c_thr     = data[15:0];
			REG_SPIKE_CD:  c_cd      = data[15:0];
			REG_GAIN:      c_gain    = data[14:0];
			REG_START:     c_start   = data[14:0];
			REG_END:       c_end     = data[14:0];
			default: ;
		endcase
	endtask

	task automatic write_regs(input int cool, input int gap, input int leak, input int thr,
			input int cd, input int gain, input int start_lv, input int end_lv);
		reg_write(REG_COOL_TILT, 16'(cool));
		reg_write(REG_MAX_GAP,   16'(gap));
		reg_write(REG_LEAK_RATE, 16'(leak));
		reg_write(REG_SPIKE_THR, 16'(thr));
		reg_write(REG_SPIKE_CD,  16'(cd));
		reg_write(REG_GAIN,      16'(gain));
		reg_write(REG_START,     16'(start_lv));
		reg_write(REG_END,       16'(end_lv));
		n_settings++;
	endtask

	task automatic write_setting(input int kind);
		int start_lv;
		case (kind)
			CFG_ZERO: write_regs(0, 0, 0, 0, 0, 0, 0, 0);
			CFG_FULL: write_regs(65535, 65535, 32767, 65535, 65535, 32767, 32767, 32767);
			CFG_RESET: write_regs(RST_COOL_TILT, RST_MAX_GAP, RST_LEAK_RATE, RST_SPIKE_THR,
				RST_SPIKE_CD, RST_GAIN, RST_START, RST_END);
			default: begin
				start_lv = $urandom_range(0, 25600);
				write_regs($urandom_range(0, 1) ? 0 : $urandom_range(1, 300),
					$urandom_range(100, 3000), $urandom_range(0, 25600),
					$urandom_range(0, 4096), $urandom_range(0, 400),
					$urandom_range(0, 12800), start_lv,
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 25600)
						: $urandom_range(0, start_lv));
			end
		endcase
	endtask

	// sample runs: mostly well-paced taps and quiet stretches, some noise
	task automatic add_random_samples(input int n);
		int r, dt, m, step;
		logic [31:0] tilt;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 55)      dt = $urandom_range(1, 60);
			else if (r < 75) dt = $urandom_range(61, 400);
			else if (r < 83) dt = 0;
			else if (r < 93) dt = $urandom_range(401, 4000);
			else if (r < 97) dt = $urandom_range(4001, 70000);
			else             dt = int'($urandom);
			gen_t += 32'(dt);

			r = $urandom_range(0, 99);
			if (r < 25) begin
				m = $urandom_range(0, 65535);
			end else if (r < 45) begin
				// jump right around the threshold
				step = int'(c_thr) + int'($urandom_range(0, 2)) - 1;
				if (step < 0)
					step = 0;
				if (gen_mag >= step && ($urandom_range(0, 1) || gen_mag + step > 65535))
					m = gen_mag - step;
				else
					m = gen_mag + step;
			end else begin
				m = gen_mag + int'($urandom_range(0, 128)) - 64;
			end
			if (m < 0)
				m = 0;
			if (m > 65535)
				m = 65535;
			gen_mag = m;

			r = $urandom_range(0, 99);
			if (r < 75)
				tilt = gen_t - 32'(c_cool) - 32'($urandom_range(0, 10000));
			else if (r < 90)
				tilt = gen_t - 32'($urandom_range(0, c_cool));
			else
				tilt = $urandom;
			push_sample(gen_t, 16'(m), tilt, 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)));
		end
	endtask

	task automatic wait_drained();
		while (in_count != queued_total || happy_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// sample driver
	always @(negedge clk) begin
		sample_t nxt;
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else if (!(sample_bus.valid && !in_taken)) begin
			if (in_gap > 0) begin
				in_gap--;
				sample_bus.valid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				nxt = sample_q.pop_front();
				sample_bus.now_ms          <= nxt.now;
				sample_bus.magnitude       <= nxt.mag;
				sample_bus.tilt_neutral_ms <= nxt.tilt;
				sample_bus.eye_now         <= nxt.eye;
				sample_bus.mouth_now       <= nxt.mouth;
				sample_bus.valid           <= 1'b1;
				in_gap = pick_gap();
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (!hold_done && res_count >= 200) begin
				hold_done = 1'b1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				if (out_taken)
					out_gap = pick_gap();
			end
		end
	end

	// monitor: check results, predict accepted samples
	always @(posedge clk) begin
		outcome_t want;
		sample_t  got;
		in_taken  = arst_n && sample_bus.valid && sample_bus.ready;
		out_taken = arst_n && result_bus.valid && result_bus.ready;
		if (out_taken) begin
			res_count++;
			if (happy_q.size() == 0) begin
				$error("result with no sample pending");
				err_count++;
			end else begin
				want = happy_q.pop_front();
				check_field("event_res",     want.ev,      result_bus.event_res);
				check_field("restore_eye",   want.r_eye,   result_bus.restore_eye);
				check_field("restore_mouth", want.r_mouth, result_bus.restore_mouth);
				check_field("happiness",     want.happy,   result_bus.happiness);
				check_field("responding",    want.active,  result_bus.responding);
				check_field("pat_counted",   want.pat,     result_bus.pat_counted);
			end
		end
		if (in_taken) begin
			got.now   = sample_bus.now_ms;
			got.mag   = sample_bus.magnitude;
			got.tilt  = sample_bus.tilt_neutral_ms;
			got.eye   = sample_bus.eye_now;
			got.mouth = sample_bus.mouth_now;
			happy_q.push_back(bucket_step(got));
			in_count++;
		end
		idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
	end

	// watchdog on stalled traffic
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	// main sequence
	initial begin
		int plan [RAND_PHASES];
		plan = '{CFG_TYPICAL, CFG_TYPICAL, CFG_ZERO, CFG_TYPICAL,
			CFG_FULL, CFG_TYPICAL, CFG_RESET, CFG_TYPICAL};

		arst_n                     = 1'b0;
		psel                       = 1'b0;
		penable                    = 1'b0;
		pwrite                     = 1'b0;
		paddr                      = '0;
		pwdata                     = '0;
		sample_bus.valid           = 1'b0;
		sample_bus.now_ms          = '0;
		sample_bus.magnitude       = '0;
		sample_bus.tilt_neutral_ms = '0;
		sample_bus.eye_now         = '0;
		sample_bus.mouth_now       = '0;
		result_bus.ready           = 1'b0;

		c_cool        = RST_COOL_TILT;
		c_max_gap     = RST_MAX_GAP;
		c_leak        = RST_LEAK_RATE;
		c_thr         = RST_SPIKE_THR;
		c_cd          = RST_SPIKE_CD;
		c_gain        = RST_GAIN;
		c_start       = RST_START;
		c_end         = RST_END;
		b_last_upd    = '0;
		b_last_pat    = '0;
		b_level       = '0;
		b_prev_mag    = '0;
		b_active      = 1'b0;
		b_saved_eye   = '0;
		b_saved_mouth = '0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		n_settings = 1;

		// reset registers: first sample at time zero, pats, cooldown, saturation
		push_sample(32'd0,    16'h0000, 32'd0, 4'h0, 4'h0);
		push_sample(32'd10,   16'hFFFF, 32'd0, 4'hF, 4'hF);
		push_sample(32'd300,  16'h0000, 32'd0, 4'h1, 4'h2);
		push_sample(32'd310,  16'h0000, 32'd0, 4'h1, 4'h2);
		push_sample(32'd310,  16'hFFFF, 32'd0, 4'h3, 4'h4);
		push_sample(32'd600,  16'h0000, 32'd0, 4'hA, 4'h5);
		push_sample(32'd800,  16'hFFFF, 32'd0, 4'hA, 4'h5);
		push_sample(32'd1000, 16'h0000, 32'd0, 4'h6, 4'h9);
		push_sample(32'd1200, 16'hFFFF, 32'd0, 4'h6, 4'h9);
		push_sample(32'd1400, 16'h0000, 32'd0, 4'h7, 4'h8);
		push_sample(32'd1600, 16'hFFFF, 32'd0, 4'h7, 4'h8);
		push_sample(32'd1800, 16'h0000, 32'd0, 4'h7, 4'h8);
		push_sample(32'd2900, 16'h0200, 32'd0, 4'h2, 4'h3);
		wait_drained();

		// tilt cooldown edge, fast leak to end, restart, time wrap
		write_regs(100, 1000, 25600, 512, 200, 25600, 25600, 2560);
		push_sample(32'd3000,       16'hFFFF, 32'd2950,       4'h5, 4'h5);
		push_sample(32'd3000,       16'hFFFF, 32'd2900,       4'h5, 4'h5);
		push_sample(32'd3300,       16'h0000, 32'd0,          4'hC, 4'h3);
		push_sample(32'd4299,       16'h0000, 32'd0,          4'h0, 4'hF);
		push_sample(32'd4500,       16'hFFFF, 32'd0,          4'hF, 4'h0);
		push_sample(32'hFFFF_FF00,  16'h0000, 32'd0,          4'h9, 4'h9);
		push_sample(32'h0000_0010,  16'hFFFF, 32'hFFFF_FF00,  4'h1, 4'h1);
		push_sample(32'h0000_0020,  16'h8000, 32'h0000_0030,  4'h2, 4'hE);
		push_sample(32'h0000_0400,  16'h0001, 32'h0000_0000,  4'hD, 4'h7);
		wait_drained();

		// random phases over several settings, extremes included
		gen_t   = $urandom;
		gen_mag = $urandom_range(0, 65535);
		for (int p = 0; p < RAND_PHASES; p++) begin
			cfg_junk = ($urandom_range(0, 2) == 0);
			write_setting(plan[p]);
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				gen_t = $urandom;
			add_random_samples(PHASE_ITEMS);
			wait_drained();
		end
		repeat (8) @(negedge clk);

		$display("covered %0d samples over %0d register settings", in_count, n_settings);
		$display("seen %0d pats, %0d starts, %0d ends, %0d samples in tilt cooldown",
			n_pat, n_start, n_end, n_ignored);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/pld_pkg.sv
hdl/pld_in_if.sv
hdl/pld_out_if.sv
hdl/pld_cfg_regs.sv
hdl/pld_core.sv
hdl/pat_leaky_bucket_detector.sv
tb/sv/pat_leaky_bucket_detector_tb.sv
